[src/cre_pkg.sv]
`default_nettype none

package cre_pkg;

  localparam logic [7:0] DASH_CHAR = 8'h2D;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_word_t;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_UPPER,
    CLS_LOWER,
    CLS_DIGIT
  } class_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RUN,
    ST_DASH
  } state_e;

  // what the oldest pending byte turns into
  typedef enum logic [1:0] {
    DEC_PASS,
    DEC_HOLD,
    DEC_RANGE,
    DEC_SPLIT
  } dec_e;

  typedef enum logic [1:0] {
    SEL_W0,
    SEL_PREV,
    SEL_DASH,
    SEL_RUN
  } sel_e;

  typedef struct packed {
    logic load;
    logic consume;
    logic run_load;
    logic run_step;
    logic line_end;
    logic emit;
    sel_e emit_sel;
    logic emit_last;
  } cre_cmd_t;

  typedef struct packed {
    dec_e       dec;
    logic [1:0] wcnt;
    logic       last;
    logic       run_done;
    logic       emit_ok;
  } cre_sts_t;

  function automatic class_e char_class(input logic [7:0] c);
    class_e k;
    k = CLS_NONE;
    if (c inside {[8'h41:8'h5A]}) k = CLS_UPPER;
    else if (c inside {[8'h61:8'h7A]}) k = CLS_LOWER;
    else if (c inside {[8'h30:8'h39]}) k = CLS_DIGIT;
    return k;
  endfunction

endpackage

`default_nettype wire

[src/cre_datapath.sv]
`default_nettype none

module cre_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cre_pkg::in_word_t  in_word_i,
  input  wire cre_pkg::cre_cmd_t  cmd_i,
  output cre_pkg::cre_sts_t       sts_o,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output cre_pkg::out_word_t      out_word_o
);
  import cre_pkg::*;

  // pending window, oldest byte in slot 0
  logic [2:0][7:0] w_q, w_d;
  logic [1:0]      wcnt_q, wcnt_d;
  logic            start_q, start_d;
  logic            last_q, last_d;
  logic [7:0]      prev_q, prev_d;
  logic [7:0]      run_cur_q, run_cur_d;
  logic [7:0]      run_end_q, run_end_d;
  logic            run_desc_q, run_desc_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;
  logic            emit_ok;
  class_e          prev_cls;
  dec_e            dec;

  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign prev_cls = char_class(prev_q);

  always_comb begin
    if (w_q[0] == DASH_CHAR) begin
      if (start_q || wcnt_q < 2'd2) begin
        dec = DEC_PASS;
      end else if (prev_cls != CLS_NONE && prev_cls == char_class(w_q[1])) begin
        dec = DEC_RANGE;
      end else begin
        dec = DEC_SPLIT;
      end
    end else if (wcnt_q == 2'd3 && w_q[1] == DASH_CHAR) begin
      dec = DEC_HOLD;
    end else begin
      dec = DEC_PASS;
    end
  end

  assign sts_o.dec      = dec;
  assign sts_o.wcnt     = wcnt_q;
  assign sts_o.last     = last_q;
  assign sts_o.run_done = (run_cur_q == run_end_q);
  assign sts_o.emit_ok  = emit_ok;

  always_comb begin
    w_d        = w_q;
    wcnt_d     = wcnt_q;
    start_d    = start_q;
    last_d     = last_q;
    prev_d     = prev_q;
    run_cur_d  = run_cur_q;
    run_end_d  = run_end_q;
    run_desc_d = run_desc_q;
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) == wcnt_q) w_d[i] = in_word_i.in_char;
      end
      wcnt_d = wcnt_q + 2'd1;
      last_d = in_word_i.in_last;
    end
    if (cmd_i.consume) begin
      w_d[0]  = w_q[1];
      w_d[1]  = w_q[2];
      wcnt_d  = wcnt_q - 2'd1;
      prev_d  = w_q[0];
      start_d = 1'b0;
    end
    if (cmd_i.run_load) begin
      run_cur_d  = prev_q;
      run_end_d  = w_q[1];
      run_desc_d = (w_q[1] < prev_q);
      w_d[0]     = w_q[2];
      wcnt_d     = wcnt_q - 2'd2;
      prev_d     = w_q[1];
      start_d    = 1'b0;
    end
    if (cmd_i.run_step) begin
      run_cur_d = run_desc_q ? run_cur_q - 8'd1 : run_cur_q + 8'd1;
    end
    if (cmd_i.line_end) begin
      wcnt_d  = 2'd0;
      start_d = 1'b1;
      last_d  = 1'b0;
      prev_d  = 8'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.emit) begin
      out_valid_d    = 1'b1;
      out_d.out_last = cmd_i.emit_last;
      case (cmd_i.emit_sel)
        SEL_W0:   out_d.out_char = w_q[0];
        SEL_PREV: out_d.out_char = prev_q;
        SEL_DASH: out_d.out_char = DASH_CHAR;
        SEL_RUN:  out_d.out_char = run_cur_q;
        default:  out_d.out_char = w_q[0];
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q      <= 2'd0;
      start_q     <= 1'b1;
      last_q      <= 1'b0;
      prev_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      wcnt_q      <= wcnt_d;
      start_q     <= start_d;
      last_q      <= last_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    run_cur_q  <= run_cur_d;
    run_end_q  <= run_end_d;
    run_desc_q <= run_desc_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

[src/cre_ctrl.sv]
`default_nettype none

module cre_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_stall_o,
  input  wire cre_pkg::cre_sts_t  sts_i,
  output cre_pkg::cre_cmd_t       cmd_o
);
  import cre_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    rem        = sts_i.wcnt - 2'd1;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i || sts_i.wcnt == 2'd2) state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (sts_i.dec)
          DEC_PASS: begin
            if (sts_i.emit_ok) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_sel  = SEL_W0;
              cmd_o.emit_last = sts_i.last && rem == 2'd0;
              cmd_o.consume   = 1'b1;
              if (sts_i.last && rem != 2'd0) begin
                state_d = ST_DECIDE;
              end else begin
                cmd_o.line_end = sts_i.last;
                state_d        = ST_IDLE;
              end
            end
          end
          DEC_HOLD: begin
            cmd_o.consume = 1'b1;
            state_d       = sts_i.last ? ST_DECIDE : ST_IDLE;
          end
          DEC_RANGE: begin
            cmd_o.run_load = 1'b1;
            state_d        = ST_RUN;
          end
          DEC_SPLIT: begin
            if (sts_i.emit_ok) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = SEL_PREV;
              state_d        = ST_DASH;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RUN: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = SEL_RUN;
          cmd_o.emit_last = sts_i.run_done && sts_i.last && sts_i.wcnt == 2'd0;
          if (!sts_i.run_done) begin
            cmd_o.run_step = 1'b1;
          end else if (sts_i.last && sts_i.wcnt != 2'd0) begin
            state_d = ST_DECIDE;
          end else begin
            cmd_o.line_end = sts_i.last;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_DASH: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_sel  = SEL_DASH;
          cmd_o.emit_last = sts_i.last && rem == 2'd0;
          cmd_o.consume   = 1'b1;
          if (sts_i.last && rem != 2'd0) begin
            state_d = ST_DECIDE;
          end else begin
            cmd_o.line_end = sts_i.last;
            state_d        = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/character_range_expander_top.sv]
// character range expander: takes a line one byte word at a time on the
// input channel and gives the expanded line on the output channel.
// both channels use valid and stall; a word moves at a clock edge with
// valid high and stall low. in_last marks the final byte of a line and
// out_last marks the final byte of the expanded line.
// bytes are held in a three-entry lookahead window, so output trails the
// input by up to two bytes until the line ends.
// a byte that needs no decision is only loaded. once the window fills,
// the oldest byte is decided: a plain byte is emitted, a range is set up
// and then emitted one character at a time (up to 26), and a dash between
// mismatched classes emits the byte before it and then the dash. at line
// end each pending byte is decided in turn; a held byte and a range setup
// emit nothing. the emit path is one output register: while the receiver
// stalls, the controller waits before an emit and the input stays stalled.
// reset (rst_ni low, asynchronous) empties the window, clears the output
// valid and puts the block at the start of a new line.
`default_nettype none

module character_range_expander_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire cre_pkg::in_word_t in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output cre_pkg::out_word_t     out_word_o
);
  import cre_pkg::*;

  cre_cmd_t cmd;
  cre_sts_t sts;

  cre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.in_last),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cre_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
